FILE: hdl/clsr_pkg.sv
// Package for the combined LCG / shuffle-table generator: constants, the
// controller-to-datapath command and status structs, and the modular fold.
// No dependencies.
`timescale 1ns / 1ps

package clsr_pkg;

  localparam int unsigned GEN_W   = 31;           // generator and output width
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned PROD_W  = 47;           // 31-bit state times 16-bit multiplier
  localparam int unsigned MUL_ONE = 40014;
  localparam int unsigned MUL_TWO = 40692;
  localparam int unsigned MOD_ONE = 2147483563;
  localparam int unsigned MOD_TWO = 2147483399;
  localparam int unsigned FOLD_ONE = 85;          // 2^31 - MOD_ONE
  localparam int unsigned FOLD_TWO = 249;         // 2^31 - MOD_TWO
  localparam int unsigned WRAP_ADD = MOD_ONE - 1;

  localparam int unsigned DEF_TABLE_SLOTS  = 32;
  localparam int unsigned DEF_WARMUP_STEPS = 8;

  typedef struct packed {
    logic load_seed;   // load both generators from the seed, arm the fill counter
    logic seed_one;    // use seed 1 rather than the input item
    logic fill_step;   // step generator one, write table at counter, count down
    logic gen_step;    // step both generators
    logic gen_out;     // form output, refill slot, load output register
    logic slot_ld;     // latch corrected slot index
  } clsr_cmd_t;

  typedef struct packed {
    logic cnt_last;    // fill counter at zero
    logic out_busy;    // output register full and not taken this cycle
  } clsr_sts_t;

  // p mod m for m = 2^31 - c: fold the high part down, then one subtract.
  // Equal to the Schrage step for any 31-bit state.
  function automatic logic [GEN_W-1:0] fold_mod(input logic [PROD_W-1:0] p,
                                                input logic [7:0]        c,
                                                input logic [31:0]       m);
    logic [31:0] t;
    t = 32'(p[30:0]) + 32'(p[PROD_W-1:31]) * 32'(c);
    if (t >= m) begin
      fold_mod = GEN_W'(t - m);
    end else begin
      fold_mod = GEN_W'(t);
    end
  endfunction

endpackage

FILE: hdl/clsr_ram.sv
// Generic single-port RAM, write-enable and registered read-first output.
// No dependencies.
`timescale 1ns / 1ps

module clsr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/clsr_datapath.sv
// Datapath: both generators, multiply/fold units, shuffle table, slot index
// and output register. Depends on clsr_pkg and clsr_ram.
`timescale 1ns / 1ps

module clsr_datapath import clsr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS  = DEF_TABLE_SLOTS,
  parameter int unsigned WARMUP_STEPS = DEF_WARMUP_STEPS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  clsr_cmd_t                cmd,
  output clsr_sts_t                sts,
  input  logic signed [SEED_W-1:0] seed_value,
  output logic [GEN_W-1:0]         random_value,
  output logic                     out_tvalid,
  input  logic                     out_tready
);

  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = (TABLE_SLOTS + WARMUP_STEPS > 1) ?
                               $clog2(TABLE_SLOTS + WARMUP_STEPS) : 1;
  localparam longint unsigned SLOT_DIV = 1 + longint'(WRAP_ADD) / TABLE_SLOTS;
  // floor(2^31 / SLOT_DIV): estimate is exact or one low
  localparam longint unsigned RECIP = 64'h8000_0000 / SLOT_DIV;
  localparam int unsigned RW  = $clog2(RECIP + 1);
  localparam int unsigned SPW = GEN_W + RW;

  logic [GEN_W-1:0]  gen1_r, gen2_r, last_r, out_data_r;
  logic [PROD_W-1:0] prod1_r, prod2_r;
  logic [SPW-1:0]    sp_r;
  logic [AW-1:0]     slot_r;
  logic [CW-1:0]     cnt_r;
  logic              out_valid_r;

  logic [GEN_W-1:0]  red1, red2, seed_c, seed_src, tab_q, tab_wdata, gen_v;
  logic [AW-1:0]     tab_addr;
  logic              tab_we, fill_in_table;
  logic [32:0]       diff;
  logic [RW-1:0]     q0;
  logic [SPW-1:0]    qd, rem;
  logic [RW:0]       qf;
  logic [AW-1:0]     slot_nxt;

  assign red1 = fold_mod(prod1_r, 8'(FOLD_ONE), 32'(MOD_ONE));
  assign red2 = fold_mod(prod2_r, 8'(FOLD_TWO), 32'(MOD_TWO));

  assign seed_c   = (seed_value < 32'sd1) ? GEN_W'(1) : seed_value[GEN_W-1:0];
  assign seed_src = cmd.seed_one ? GEN_W'(1) : seed_c;

  assign fill_in_table = ({1'b0, cnt_r} < (CW+1)'(TABLE_SLOTS));
  assign tab_we    = (cmd.fill_step && fill_in_table) || cmd.gen_out;
  assign tab_addr  = cmd.fill_step ? cnt_r[AW-1:0] : slot_r;
  assign tab_wdata = cmd.fill_step ? red1 : gen1_r;

  clsr_ram #(
    .WIDTH(GEN_W),
    .DEPTH(TABLE_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (tab_we),
    .addr (tab_addr),
    .wdata(tab_wdata),
    .rdata(tab_q)
  );

  // entry minus generator two, wrapped into 1..WRAP_ADD
  assign diff  = {2'b00, tab_q} - {2'b00, gen2_r};
  assign gen_v = (diff[32] || diff == 33'd0) ? GEN_W'(diff + 33'(WRAP_ADD))
                                             : GEN_W'(diff);

  // slot = last / SLOT_DIV by reciprocal estimate plus one correction
  assign q0  = sp_r[SPW-1:GEN_W];
  assign qd  = SPW'(q0) * SPW'(SLOT_DIV);
  assign rem = SPW'(last_r) - qd;
  assign qf  = (RW+1)'(q0) + (RW+1)'(rem >= SPW'(SLOT_DIV));
  assign slot_nxt = (qf >= (RW+1)'(TABLE_SLOTS)) ? AW'(TABLE_SLOTS - 1) : AW'(qf);

  // multipliers run every cycle; the controller's *_MUL states let the products settle
  always_ff @(posedge clk) begin
    prod1_r <= PROD_W'(gen1_r) * PROD_W'(MUL_ONE);
    prod2_r <= PROD_W'(gen2_r) * PROD_W'(MUL_TWO);
    sp_r    <= SPW'(last_r) * SPW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      gen1_r <= seed_src;
      gen2_r <= seed_src;
      cnt_r  <= CW'(TABLE_SLOTS + WARMUP_STEPS - 1);
    end else if (cmd.fill_step) begin
      gen1_r <= red1;
      if (cnt_r == '0) begin
        last_r <= red1;
      end else begin
        cnt_r <= cnt_r - CW'(1);
      end
    end else if (cmd.gen_step) begin
      gen1_r <= red1;
      gen2_r <= red2;
    end
    if (cmd.gen_out) begin
      last_r     <= gen_v;
      out_data_r <= gen_v;
    end
    if (cmd.slot_ld) begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.gen_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.cnt_last  = (cnt_r == '0);
  assign sts.out_busy  = out_valid_r && !out_tready;
  assign random_value  = out_data_r;
  assign out_tvalid    = out_valid_r;

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r != '0) && (out_data_r <= GEN_W'(WRAP_ADD)))
    else $error("output outside 1..WRAP_ADD");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_ld |=> (32'(slot_r) < TABLE_SLOTS))
    else $error("slot index beyond table");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_out |=> out_valid_r)
    else $error("generated item not presented");

endmodule

FILE: hdl/clsr_ctrl.sv
// Controller FSM: sequences seeding, table fill, generation and slot update.
// Depends on clsr_pkg.
`timescale 1ns / 1ps

module clsr_ctrl import clsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_command,
  output logic      in_tready,
  input  clsr_sts_t sts,
  output clsr_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_RST_LOAD,
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_GEN_MUL,
    ST_GEN_RED,
    ST_GEN_OUT,
    ST_SLOT_MUL,
    ST_SLOT_FIX
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_RST_LOAD: begin
        cmd.load_seed = 1'b1;
        cmd.seed_one  = 1'b1;
        state_nxt     = ST_SEED_MUL;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_command) begin
            cmd.load_seed = 1'b1;
            state_nxt     = ST_SEED_MUL;
          end else begin
            state_nxt = ST_GEN_MUL;
          end
        end
      end
      ST_SEED_MUL: state_nxt = ST_SEED_RED;
      ST_SEED_RED: begin
        cmd.fill_step = 1'b1;
        state_nxt     = sts.cnt_last ? ST_SLOT_MUL : ST_SEED_MUL;
      end
      ST_GEN_MUL: state_nxt = ST_GEN_RED;
      ST_GEN_RED: begin
        cmd.gen_step = 1'b1;
        state_nxt    = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        // hold until the output register can take the item
        if (!sts.out_busy) begin
          cmd.gen_out = 1'b1;
          state_nxt   = ST_SLOT_MUL;
        end
      end
      ST_SLOT_MUL: state_nxt = ST_SLOT_FIX;
      ST_SLOT_FIX: begin
        cmd.slot_ld = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_RST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("accepted a second item while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_out |-> !sts.out_busy)
    else $error("output register overwritten");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_seed, cmd.fill_step, cmd.gen_step, cmd.gen_out, cmd.slot_ld}))
    else $error("conflicting datapath commands");

endmodule

FILE: hdl/combined_lcg_shuffle_rng_unit.sv
// Combined two-sequence multiplicative LCG with shuffle table, top level.
// Generate item: after accept the FSM steps GEN_MUL, GEN_RED and GEN_OUT, which raises out_tvalid
// (GEN_OUT waits while out_tvalid is high and out_tready low), then SLOT_MUL and SLOT_FIX.
// Seed item: no result; busy while the table is filled, one SEED_MUL/SEED_RED pair per fill step.
// Reset (rst_n low, synchronous) reseeds with 1: in_tready rises once that seeding is done.
// Depends on clsr_pkg, clsr_ctrl, clsr_datapath.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_unit import clsr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS  = DEF_TABLE_SLOTS,   // 1..256
  parameter int unsigned WARMUP_STEPS = DEF_WARMUP_STEPS   // 0..64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] seed_value (signed)
  input  logic [0:0]  in_tuser,    // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // [30:0] random_value, [31] zero
);

  clsr_cmd_t        cmd;
  clsr_sts_t        sts;
  logic [GEN_W-1:0] random_value;

  clsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_command(in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clsr_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .WARMUP_STEPS(WARMUP_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .seed_value  ($signed(in_tdata)),
    .random_value(random_value),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready)
  );

  assign out_tdata = {1'b0, random_value};

endmodule
